// File: sv/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared field widths, register indexes, item op codes and status codes
// for the tile permutation remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpr_pkg;

  localparam int OP_W       = 2;
  localparam int DRAW_W     = 31;
  localparam int TILE_W     = 10;
  localparam int COORD_W    = 16;
  localparam int STAT_W     = 2;
  localparam int TSIZE_W    = 9;
  localparam int TILES_W    = 6;
  localparam int THRESH_W   = 16;
  localparam int ORIGIN_W   = 15;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TSIZE_W-1:0] DEFAULT_TILE_SIZE = 9'd32;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_THRESH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd7;

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
  localparam logic [OP_W-1:0] OP_MAP     = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_EFFECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FEW_TILES = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

endpackage

`default_nettype wire

// File: sv/tpr_ram.sv
// ----------------------------------------------------------------------------
// tpr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/tpr_div.sv
// ----------------------------------------------------------------------------
// tpr_div
// Restoring serial divider, one quotient bit per cycle. Quotient and
// remainder hold after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module tpr_div #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quot,
  output logic      [DVS_W-1:0] rem
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem, quot[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= STEP_W'(DVD_W);
      end else if (active) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (active) begin
      quot <= {quot[DVD_W-2:0], fits};
      rem  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/tile_permutation_remap.sv
// ----------------------------------------------------------------------------
// tile_permutation_remap
// Tile order table with init, Fisher-Yates shuffle step and tile map items.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until the result
// strobe. An init item makes one table write per tile. A shuffle item and a
// map item each wait on a serial divider over the 31-bit dividend (draw mod
// (i+1) for a shuffle, tile and entry split by tiles_across for a map), plus
// the table read, read-modify-write and multiply stages. Items that answer a
// non-zero status finish straight from the decide state. Each result is shown
// for one cycle with done; the receiver cannot stall. The table has no clearing
// pass: entries never written by an init read as anything.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_permutation_remap #(
  parameter int MAX_TILES = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [tpr_pkg::OP_W-1:0]         op,
  input  wire logic [tpr_pkg::DRAW_W-1:0]       draw,
  input  wire logic [tpr_pkg::TILE_W-1:0]       tile,
  output logic                                  done,
  output logic      [tpr_pkg::COORD_W-1:0]      src_x,
  output logic      [tpr_pkg::COORD_W-1:0]      src_y,
  output logic      [tpr_pkg::COORD_W-1:0]      dst_x,
  output logic      [tpr_pkg::COORD_W-1:0]      dst_y,
  output logic                                  copy_tile,
  output logic      [tpr_pkg::STAT_W-1:0]       status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W  = $clog2(MAX_TILES);
  localparam int CNT_W  = $clog2(MAX_TILES + 1);
  localparam int DVS_W  = (CNT_W > tpr_pkg::TILES_W) ? CNT_W : tpr_pkg::TILES_W;
  localparam int PROD_W = 2 * tpr_pkg::TILES_W;
  localparam int NCMP_W = (PROD_W > CNT_W) ? PROD_W : CNT_W;
  localparam int TCMP_W = (tpr_pkg::TILE_W > CNT_W) ? tpr_pkg::TILE_W : CNT_W;
  localparam int CW     = tpr_pkg::COORD_W;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_DECIDE  = 12'b0000_0000_0010,
    ST_INIT    = 12'b0000_0000_0100,
    ST_SH_DIV  = 12'b0000_0000_1000,
    ST_SH_RDI  = 12'b0000_0001_0000,
    ST_SH_RDJ  = 12'b0000_0010_0000,
    ST_SH_WRI  = 12'b0000_0100_0000,
    ST_SH_WRJ  = 12'b0000_1000_0000,
    ST_MAP_RD  = 12'b0001_0000_0000,
    ST_MAP_DIV = 12'b0010_0000_0000,
    ST_MAP_MUL = 12'b0100_0000_0000,
    ST_MAP_SUM = 12'b1000_0000_0000
  } state_t;

  // configuration
  logic [tpr_pkg::TSIZE_W-1:0]  tile_width;
  logic [tpr_pkg::TSIZE_W-1:0]  tile_height;
  logic [tpr_pkg::TILES_W-1:0]  tiles_across;
  logic [tpr_pkg::TILES_W-1:0]  tiles_down;
  logic                         random_mode;
  logic [tpr_pkg::THRESH_W-1:0] keep_threshold;
  logic [tpr_pkg::ORIGIN_W-1:0] origin_x;
  logic [tpr_pkg::ORIGIN_W-1:0] origin_y;

  state_t                      state;
  state_t                      state_next;
  logic                        finish;
  logic [tpr_pkg::STAT_W-1:0]  fin_status;

  logic [tpr_pkg::OP_W-1:0]    op_q;
  logic [tpr_pkg::DRAW_W-1:0]  draw_q;
  logic [tpr_pkg::TILE_W-1:0]  tile_q;
  logic [IDX_W-1:0]            pos;
  logic [CNT_W-1:0]            fill;
  logic [IDX_W-1:0]            swap_tmp;

  logic [PROD_W-1:0]           tile_prod;
  logic [CNT_W-1:0]            n;
  logic                        few;
  logic                        tile_oob;
  logic                        sh_go;
  logic                        map_go;
  logic [IDX_W-1:0]            sh_j;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_wr_addr;
  logic [IDX_W-1:0]            ram_wr_data;
  logic                        ram_rd_en;
  logic [IDX_W-1:0]            ram_rd_addr;
  logic [IDX_W-1:0]            ram_rd_data;

  logic                        a_start;
  logic [tpr_pkg::DRAW_W-1:0]  a_dividend;
  logic [DVS_W-1:0]            a_divisor;
  logic                        a_done;
  logic [tpr_pkg::DRAW_W-1:0]  a_quot;
  logic [DVS_W-1:0]            a_rem;
  logic                        b_start;
  logic                        b_done;
  logic [tpr_pkg::DRAW_W-1:0]  b_quot;
  logic [DVS_W-1:0]            b_rem;

  logic [CW-1:0]               tw_eff;
  logic [CW-1:0]               th_eff;
  logic [CW-1:0]               prod_sx;
  logic [CW-1:0]               prod_sy;
  logic [CW-1:0]               prod_dx;
  logic [CW-1:0]               prod_dy;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width     <= tpr_pkg::DEFAULT_TILE_SIZE;
      tile_height    <= tpr_pkg::DEFAULT_TILE_SIZE;
      tiles_across   <= tpr_pkg::TILES_W'(1);
      tiles_down     <= tpr_pkg::TILES_W'(1);
      random_mode    <= 1'b0;
      keep_threshold <= '1;
      origin_x       <= '0;
      origin_y       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpr_pkg::REG_TILE_WIDTH:   tile_width     <= cfg_data[tpr_pkg::TSIZE_W-1:0];
        tpr_pkg::REG_TILE_HEIGHT:  tile_height    <= cfg_data[tpr_pkg::TSIZE_W-1:0];
        tpr_pkg::REG_TILES_ACROSS: tiles_across   <= cfg_data[tpr_pkg::TILES_W-1:0];
        tpr_pkg::REG_TILES_DOWN:   tiles_down     <= cfg_data[tpr_pkg::TILES_W-1:0];
        tpr_pkg::REG_RANDOM_MODE:  random_mode    <= cfg_data[0];
        tpr_pkg::REG_KEEP_THRESH:  keep_threshold <= cfg_data[tpr_pkg::THRESH_W-1:0];
        tpr_pkg::REG_ORIGIN_X:     origin_x       <= cfg_data[tpr_pkg::ORIGIN_W-1:0];
        tpr_pkg::REG_ORIGIN_Y:     origin_y       <= cfg_data[tpr_pkg::ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // tile count, saturated at the table depth
  assign tile_prod = PROD_W'(tiles_across) * PROD_W'(tiles_down);
  assign n = (NCMP_W'(tile_prod) > NCMP_W'(MAX_TILES)) ? CNT_W'(MAX_TILES)
                                                       : CNT_W'(tile_prod);
  assign few      = (n <= CNT_W'(1));
  assign tile_oob = (TCMP_W'(tile_q) >= TCMP_W'(n));
  assign sh_go    = (op_q == tpr_pkg::OP_SHUFFLE) && !few && random_mode &&
                    (pos != '0) && (CNT_W'(pos) < n);
  assign map_go   = (op_q == tpr_pkg::OP_MAP) && !few && !tile_oob;
  assign sh_j     = a_rem[IDX_W-1:0];

  assign tw_eff = CW'((tile_width  == '0) ? tpr_pkg::DEFAULT_TILE_SIZE : tile_width);
  assign th_eff = CW'((tile_height == '0) ? tpr_pkg::DEFAULT_TILE_SIZE : tile_height);

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    fin_status = tpr_pkg::STAT_OK;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        finish = 1'b1;
        case (op_q)
          tpr_pkg::OP_INIT: begin
            if (few) begin
              fin_status = tpr_pkg::STAT_FEW_TILES;
            end else begin
              finish = 1'b0;
              state_next = ST_INIT;
            end
          end
          tpr_pkg::OP_SHUFFLE: begin
            if (few) begin
              fin_status = tpr_pkg::STAT_FEW_TILES;
            end else if (sh_go) begin
              finish = 1'b0;
              state_next = ST_SH_DIV;
            end else begin
              fin_status = tpr_pkg::STAT_NO_EFFECT;
            end
          end
          tpr_pkg::OP_MAP: begin
            if (few) begin
              fin_status = tpr_pkg::STAT_FEW_TILES;
            end else if (tile_oob) begin
              fin_status = tpr_pkg::STAT_RANGE;
            end else begin
              finish = 1'b0;
              state_next = ST_MAP_RD;
            end
          end
          default: fin_status = tpr_pkg::STAT_NO_EFFECT;
        endcase
        if (finish) state_next = ST_IDLE;
      end
      ST_INIT: begin
        if (fill == n - CNT_W'(1)) begin
          finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SH_DIV: begin
        if (a_done) state_next = ST_SH_RDI;
      end
      ST_SH_RDI:  state_next = ST_SH_RDJ;
      ST_SH_RDJ:  state_next = ST_SH_WRI;
      ST_SH_WRI:  state_next = ST_SH_WRJ;
      ST_SH_WRJ: begin
        finish = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MAP_RD:  state_next = ST_MAP_DIV;
      ST_MAP_DIV: begin
        if (b_done) state_next = ST_MAP_MUL;
      end
      ST_MAP_MUL: state_next = ST_MAP_SUM;
      ST_MAP_SUM: begin
        finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      pos   <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      case (state)
        ST_DECIDE: fill <= '0;
        ST_INIT: begin
          fill <= fill + CNT_W'(1);
          pos  <= IDX_W'(n - CNT_W'(1));
        end
        ST_SH_WRJ: pos <= pos - IDX_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_q   <= op;
      draw_q <= draw;
      tile_q <= tile;
    end
    if (state == ST_SH_RDJ) begin
      swap_tmp <= ram_rd_data;
    end
    if (state == ST_MAP_MUL) begin
      prod_sx <= CW'(a_rem[tpr_pkg::TILES_W-1:0]) * tw_eff;
      prod_sy <= a_quot[CW-1:0] * th_eff;
      prod_dx <= CW'(b_rem[tpr_pkg::TILES_W-1:0]) * tw_eff;
      prod_dy <= b_quot[CW-1:0] * th_eff;
    end
    if (finish) begin
      status <= fin_status;
      if (state == ST_MAP_SUM) begin
        src_x     <= CW'(origin_x) + prod_sx;
        src_y     <= CW'(origin_y) + prod_sy;
        dst_x     <= CW'(origin_x) + prod_dx;
        dst_y     <= CW'(origin_y) + prod_dy;
        copy_tile <= (draw_q[tpr_pkg::DRAW_W-1:tpr_pkg::DRAW_W-tpr_pkg::THRESH_W]
                      <= keep_threshold);
      end else begin
        src_x     <= '0;
        src_y     <= '0;
        dst_x     <= '0;
        dst_y     <= '0;
        copy_tile <= 1'b0;
      end
    end
  end

  // table port control
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    case (state)
      ST_DECIDE: begin
        ram_rd_en   = map_go;
        ram_rd_addr = IDX_W'(tile_q);
      end
      ST_INIT: begin
        ram_we      = 1'b1;
        ram_wr_addr = fill[IDX_W-1:0];
        ram_wr_data = random_mode ? fill[IDX_W-1:0] : IDX_W'(n - CNT_W'(1) - fill);
      end
      ST_SH_RDI: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos;
      end
      ST_SH_RDJ: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = sh_j;
      end
      ST_SH_WRI: begin
        ram_we      = 1'b1;
        ram_wr_addr = pos;
        ram_wr_data = ram_rd_data;
      end
      ST_SH_WRJ: begin
        ram_we      = 1'b1;
        ram_wr_addr = sh_j;
        ram_wr_data = swap_tmp;
      end
      default: ;
    endcase
  end

  tpr_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_TILES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // divider A: swap partner for shuffle, source tile split for map
  assign a_start    = (state == ST_DECIDE) && (sh_go || map_go);
  assign a_dividend = (op_q == tpr_pkg::OP_SHUFFLE) ? draw_q
                                                    : tpr_pkg::DRAW_W'(tile_q);
  assign a_divisor  = (op_q == tpr_pkg::OP_SHUFFLE) ? DVS_W'(pos) + DVS_W'(1)
                                                    : DVS_W'(tiles_across);

  tpr_div #(
    .DVD_W (tpr_pkg::DRAW_W),
    .DVS_W (DVS_W)
  ) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (a_start),
    .dividend (a_dividend),
    .divisor  (a_divisor),
    .done     (a_done),
    .quot     (a_quot),
    .rem      (a_rem)
  );

  // divider B: destination tile split for map
  assign b_start = (state == ST_MAP_RD);

  tpr_div #(
    .DVD_W (tpr_pkg::DRAW_W),
    .DVS_W (DVS_W)
  ) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (b_start),
    .dividend (tpr_pkg::DRAW_W'(ram_rd_data)),
    .divisor  (DVS_W'(tiles_across)),
    .done     (b_done),
    .quot     (b_quot),
    .rem      (b_rem)
  );

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != ST_IDLE)
    else $error("result strobe without a request in progress");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CNT_W'(ram_wr_addr) < n))
    else $error("table write beyond tile count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (done && status != tpr_pkg::STAT_OK) |->
      (copy_tile == 1'b0 && src_x == '0 && dst_x == '0))
    else $error("non-zero fields on error status");

  a_pos_steps_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SH_WRJ) |=> (pos == $past(pos) - IDX_W'(1)))
    else $error("shuffle position did not step down");

endmodule

`default_nettype wire
